[src/kpd_pkg.sv]
`timescale 1ns / 1ps

package kpd_pkg;

  // scanner phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_DEBOUNCE  = 5'b00010,
    PH_SCAN      = 5'b00100,
    PH_WAIT_KEY  = 5'b01000,
    PH_WAIT_DONE = 5'b10000
  } phase_t;

  localparam logic [4:0]  NO_KEY        = 5'd16;
  localparam logic [4:0]  KEY_CONFIRM   = 5'd15;
  localparam logic [4:0]  KEY_LAST_DIGIT = 5'd9;
  localparam logic [3:0]  DRIVE_ALL     = 4'hf;
  localparam logic [15:0] DEBOUNCE_RESET = 16'd5000;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] debounce_count;
    logic [1:0]  scan_column;
    logic [4:0]  found_key;
    logic [9:0]  accumulator;
    logic [1:0]  digits_taken;
  } kpd_state_t;

  typedef struct packed {
    logic [3:0] col_drive;
    logic       key_valid;
    logic [3:0] key_code;
    logic [9:0] entry_value;
    logic       entry_done;
    logic [1:0] digit_count;
  } kpd_result_t;

  // fixed key layout: column index, row index
  function automatic logic [3:0] key_lookup(input logic [1:0] col, input logic [1:0] row);
    logic [3:0] code;
    unique case ({col, row})
      4'h0: code = 4'd13;
      4'h1: code = 4'd0;
      4'h2: code = 4'd14;
      4'h3: code = 4'd15;
      4'h4: code = 4'd7;
      4'h5: code = 4'd8;
      4'h6: code = 4'd9;
      4'h7: code = 4'd12;
      4'h8: code = 4'd4;
      4'h9: code = 4'd5;
      4'ha: code = 4'd6;
      4'hb: code = 4'd11;
      4'hc: code = 4'd1;
      4'hd: code = 4'd2;
      4'he: code = 4'd3;
      default: code = 4'd10;
    endcase
    return code;
  endfunction

endpackage

[src/kpd_step.sv]
`timescale 1ns / 1ps

module kpd_step #(
  parameter int MAX_DIGITS = 3
) (
  input  kpd_pkg::kpd_state_t  state,
  input  logic [3:0]           rows,
  input  logic [15:0]          debounce_ticks,
  output kpd_pkg::kpd_state_t  state_next,
  output kpd_pkg::kpd_result_t result
);

  logic        row_hit;
  logic [1:0]  row_idx;
  logic [4:0]  found_next;
  logic [13:0] acc_wide;
  logic [1:0]  digits_inc;
  logic [1:0]  col_inc;

  // single active row only
  always_comb begin
    row_hit = 1'b1;
    row_idx = 2'd0;
    unique case (rows)
      4'b0001: row_idx = 2'd0;
      4'b0010: row_idx = 2'd1;
      4'b0100: row_idx = 2'd2;
      4'b1000: row_idx = 2'd3;
      default: row_hit = 1'b0;
    endcase
  end

  assign found_next = row_hit ? {1'b0, kpd_pkg::key_lookup(state.scan_column, row_idx)}
                              : state.found_key;
  // value * 10 + digit as shifts and adds
  assign acc_wide   = ({4'd0, state.accumulator} << 3) + ({4'd0, state.accumulator} << 1)
                      + {9'd0, found_next};
  assign digits_inc = state.digits_taken + 2'd1;
  assign col_inc    = state.scan_column + 2'd1;

  always_comb begin
    state_next         = state;
    result.col_drive   = kpd_pkg::DRIVE_ALL;
    result.key_valid   = 1'b0;
    result.key_code    = 4'd0;
    result.entry_done  = 1'b0;

    unique case (state.phase)
      kpd_pkg::PH_IDLE: begin
        if (rows != 4'd0) begin
          state_next.debounce_count = debounce_ticks;
          state_next.phase          = kpd_pkg::PH_DEBOUNCE;
        end
      end
      kpd_pkg::PH_DEBOUNCE: begin
        if (state.debounce_count > 16'd1) begin
          state_next.debounce_count = state.debounce_count - 16'd1;
        end else begin
          state_next.debounce_count = 16'd0;
          if (rows == 4'd0) begin
            state_next.phase = kpd_pkg::PH_IDLE;
          end else begin
            state_next.phase       = kpd_pkg::PH_SCAN;
            state_next.scan_column = 2'd0;
            state_next.found_key   = kpd_pkg::NO_KEY;
            result.col_drive       = 4'b0001;
          end
        end
      end
      kpd_pkg::PH_SCAN: begin
        state_next.found_key = found_next;
        if (state.scan_column != 2'd3) begin
          state_next.scan_column = col_inc;
          result.col_drive       = 4'b0001 << col_inc;
        end else begin
          state_next.scan_column = 2'd0;
          state_next.phase       = kpd_pkg::PH_IDLE;
          state_next.found_key   = kpd_pkg::NO_KEY;
          if (found_next != kpd_pkg::NO_KEY) begin
            result.key_valid = 1'b1;
            result.key_code  = found_next[3:0];
            if (found_next == kpd_pkg::KEY_CONFIRM) begin
              result.entry_done = 1'b1;
              state_next.phase  = kpd_pkg::PH_WAIT_DONE;
            end else if (found_next <= kpd_pkg::KEY_LAST_DIGIT) begin
              state_next.accumulator  = acc_wide[9:0];
              state_next.digits_taken = digits_inc;
              if (digits_inc >= 2'(MAX_DIGITS)) begin
                result.entry_done = 1'b1;
                state_next.phase  = kpd_pkg::PH_WAIT_DONE;
              end else begin
                state_next.phase = kpd_pkg::PH_WAIT_KEY;
              end
            end
          end
        end
      end
      kpd_pkg::PH_WAIT_KEY: begin
        if (rows == 4'd0) begin
          state_next.phase = kpd_pkg::PH_IDLE;
        end
      end
      kpd_pkg::PH_WAIT_DONE: begin
        if (rows == 4'd0) begin
          state_next.accumulator  = 10'd0;
          state_next.digits_taken = 2'd0;
          state_next.phase        = kpd_pkg::PH_IDLE;
        end
      end
      default: begin
        state_next.phase = kpd_pkg::PH_IDLE;
      end
    endcase

    result.entry_value = state_next.accumulator;
    result.digit_count = state_next.digits_taken;
  end

endmodule

[src/keypad_scan_decimal_entry_unit.sv]
`timescale 1ns / 1ps

// channel   | handshake             | payload
// ----------+-----------------------+----------------------------------------------
// cfg       | cfg_valid / cfg_ready | debounce_ticks[15:0]
// in        | in_valid / in_ready   | row_lines[3:0]
// out       | out_valid / out_ready | col_drive, key_valid, key_code, entry_value,
//           |                       | entry_done, digit_count
//
// one row sample beat gives one result beat; the result register is loaded on the
// edge that takes the sample, and a new sample is taken every cycle while the
// result is being drained. rst (synchronous) returns the scanner to idle, clears
// the entry and sets debounce_ticks to 5000. when out is stalled the result
// register holds and in_ready drops until it is taken.

module keypad_scan_decimal_entry_unit #(
  parameter int MAX_DIGITS = 3
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] debounce_ticks,
  // row samples
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  row_lines,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  col_drive,
  output logic        key_valid,
  output logic [3:0]  key_code,
  output logic [9:0]  entry_value,
  output logic        entry_done,
  output logic [1:0]  digit_count
);

  logic                 in_beat;
  logic [15:0]          debounce_reg;
  kpd_pkg::kpd_state_t  state;
  kpd_pkg::kpd_state_t  state_next;
  kpd_pkg::kpd_result_t step_result;
  kpd_pkg::kpd_result_t result;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // room in the result register, or it empties this cycle
  assign in_ready = !out_valid || out_ready;
  assign in_beat  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_reg <= kpd_pkg::DEBOUNCE_RESET;
    end else if (cfg_valid) begin
      debounce_reg <= debounce_ticks;
    end
  end

  // all per-sample work happens in one combinational step
  kpd_step #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_step (
    .state          (state),
    .rows           (row_lines),
    .debounce_ticks (debounce_reg),
    .state_next     (state_next),
    .result         (step_result)
  );

  // scanner state advances only on an accepted sample beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase          <= kpd_pkg::PH_IDLE;
      state.debounce_count <= 16'd0;
      state.scan_column    <= 2'd0;
      state.found_key      <= kpd_pkg::NO_KEY;
      state.accumulator    <= 10'd0;
      state.digits_taken   <= 2'd0;
    end else if (in_beat) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_beat) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      result <= step_result;
    end
  end

  assign col_drive   = result.col_drive;
  assign key_valid   = result.key_valid;
  assign key_code    = result.key_code;
  assign entry_value = result.entry_value;
  assign entry_done  = result.entry_done;
  assign digit_count = result.digit_count;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int DIGITS_PER_ENTRY = 3;
  localparam int DECIMAL_BASE = 10;
  // chance in a hundred that a side idles in a given cycle
  localparam int IDLE_PCT = 27;
  // long receiver hold-off, long enough to back the block up into its input
  localparam int HOLD_OFF_CYCLES = 400;
  // key layout as nibbles, index = column * 4 + row
  localparam logic [63:0] KEY_GRID = 64'hA321_B654_C987_FE0D;

  // expected-result tracker: own copy of the scanner state, one expected
  // result per accepted row sample, results checked in order
  class entry_scoreboard;
    kpd_pkg::phase_t      ph;
    logic [15:0]          db_ticks;
    logic [15:0]          db_count;
    logic [1:0]           col;
    logic [4:0]           found;
    logic [9:0]           acc;
    logic [1:0]           digits;
    // column drive the block will present for the next row sample
    logic [3:0]           drive_now;
    kpd_pkg::kpd_result_t expected_q[$];
    int                   mismatches;

    function new();
      ph = kpd_pkg::PH_IDLE;
      db_ticks = kpd_pkg::DEBOUNCE_RESET;
      db_count = '0;
      col = '0;
      found = kpd_pkg::NO_KEY;
      acc = '0;
      digits = '0;
      drive_now = kpd_pkg::DRIVE_ALL;
      mismatches = 0;
    endfunction

    function void set_debounce(logic [15:0] ticks);
      db_ticks = ticks;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // advance the scanner by one row sample
    function void note_rows(logic [3:0] rows);
      kpd_pkg::kpd_result_t r;
      int hits;
      int ridx;
      r = '0;
      r.col_drive = kpd_pkg::DRIVE_ALL;
      hits = 0;
      ridx = 0;
      unique case (ph)
        kpd_pkg::PH_IDLE: begin
          if (rows != 4'h0) begin
            db_count = db_ticks;
            ph = kpd_pkg::PH_DEBOUNCE;
          end
        end
        kpd_pkg::PH_DEBOUNCE: begin
          if (db_count > 16'd1) begin
            db_count = db_count - 16'd1;
          end else begin
            db_count = '0;
            if (rows == 4'h0) begin
              ph = kpd_pkg::PH_IDLE;
            end else begin
              ph = kpd_pkg::PH_SCAN;
              col = '0;
              found = kpd_pkg::NO_KEY;
              r.col_drive = 4'b0001;
            end
          end
        end
        kpd_pkg::PH_SCAN: begin
          for (int i = 0; i < 4; i++) begin
            if (rows[i]) begin
              hits++;
              ridx = i;
            end
          end
          // only a single active row decodes; a later column overrides
          if (hits == 1) found = {1'b0, KEY_GRID[(col * 4 + ridx) * 4 +: 4]};
          if (col < 2'd3) begin
            col = col + 2'd1;
            r.col_drive = 4'b0001 << col;
          end else begin
            col = '0;
            ph = kpd_pkg::PH_IDLE;
            if (found != kpd_pkg::NO_KEY) begin
              r.key_valid = 1'b1;
              r.key_code = found[3:0];
              if (found == kpd_pkg::KEY_CONFIRM) begin
                r.entry_done = 1'b1;
                ph = kpd_pkg::PH_WAIT_DONE;
              end else if (found <= kpd_pkg::KEY_LAST_DIGIT) begin
                acc = 10'(acc * DECIMAL_BASE + found);
                digits = digits + 2'd1;
                if (digits >= DIGITS_PER_ENTRY) begin
                  r.entry_done = 1'b1;
                  ph = kpd_pkg::PH_WAIT_DONE;
                end else begin
                  ph = kpd_pkg::PH_WAIT_KEY;
                end
              end
            end
            found = kpd_pkg::NO_KEY;
          end
        end
        kpd_pkg::PH_WAIT_KEY: begin
          if (rows == 4'h0) ph = kpd_pkg::PH_IDLE;
        end
        kpd_pkg::PH_WAIT_DONE: begin
          if (rows == 4'h0) begin
            acc = '0;
            digits = '0;
            ph = kpd_pkg::PH_IDLE;
          end
        end
        default: ph = kpd_pkg::PH_IDLE;
      endcase
      r.entry_value = acc;
      r.digit_count = digits;
      drive_now = r.col_drive;
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("testbench: mismatch in %s: got %0d, expected %0d", what, got, want);
      mismatches++;
    endtask

    task check_result(kpd_pkg::kpd_result_t seen);
      kpd_pkg::kpd_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result beat with nothing pending", 1, 0);
        return;
      end
      want = expected_q.pop_front();
      if (seen.col_drive != want.col_drive)
        report_mismatch("col_drive", seen.col_drive, want.col_drive);
      if (seen.key_valid != want.key_valid)
        report_mismatch("key_valid", seen.key_valid, want.key_valid);
      if (seen.key_code != want.key_code)
        report_mismatch("key_code", seen.key_code, want.key_code);
      if (seen.entry_value != want.entry_value)
        report_mismatch("entry_value", seen.entry_value, want.entry_value);
      if (seen.entry_done != want.entry_done)
        report_mismatch("entry_done", seen.entry_done, want.entry_done);
      if (seen.digit_count != want.digit_count)
        report_mismatch("digit_count", seen.digit_count, want.digit_count);
    endtask
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] debounce_ticks = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  row_lines = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  col_drive;
  logic        key_valid;
  logic [3:0]  key_code;
  logic [9:0]  entry_value;
  logic        entry_done;
  logic [1:0]  digit_count;

  entry_scoreboard sb;
  // debounce setting currently in the block, for sizing key presses
  int  cur_db = kpd_pkg::DEBOUNCE_RESET;
  int  items_offered = 0;
  // no idling on either side while set
  bit  no_idle = 1'b0;
  // receiver picks this up and holds off for that many cycles
  int  stall_request = 0;
  int  stall_left = 0;

  keypad_scan_decimal_entry_unit #(
    .MAX_DIGITS(DIGITS_PER_ENTRY)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .debounce_ticks(debounce_ticks),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .row_lines(row_lines),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .col_drive(col_drive),
    .key_valid(key_valid),
    .key_code(key_code),
    .entry_value(entry_value),
    .entry_done(entry_done),
    .digit_count(digit_count)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // receiver: random stalls, plus the long hold-off counted down here
  always @(negedge clk) begin
    if (stall_request > 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    kpd_pkg::kpd_result_t seen;
    if (!rst && out_valid && out_ready) begin
      seen.col_drive = col_drive;
      seen.key_valid = key_valid;
      seen.key_code = key_code;
      seen.entry_value = entry_value;
      seen.entry_done = entry_done;
      seen.digit_count = digit_count;
      sb.check_result(seen);
    end
  end

  // rows the keypad returns for a set of held keys under a column drive;
  // held bit index = column * 4 + row
  function automatic logic [3:0] rows_under(logic [15:0] held, logic [3:0] drive);
    logic [3:0] rows;
    rows = 4'h0;
    for (int c = 0; c < 4; c++) begin
      if (drive[c]) rows = rows | held[c * 4 +: 4];
    end
    return rows;
  endfunction

  function automatic logic [15:0] key_mask(logic [3:0] code);
    logic [15:0] mask;
    mask = '0;
    for (int i = 0; i < 16; i++) begin
      if (KEY_GRID[i * 4 +: 4] == code) mask = 16'b1 << i;
    end
    return mask;
  endfunction

  // a setting of 0 debounces like 1
  function automatic int debounce_span();
    return (cur_db == 0) ? 1 : cur_db;
  endfunction

  // one row sample beat; entered and left at a falling edge, valid left high
  task automatic send_rows(input logic [3:0] rows);
    while (!no_idle && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    row_lines <= rows;
    do @(posedge clk); while (!in_ready);
    sb.note_rows(rows);
    items_offered++;
    @(negedge clk);
  endtask

  // stop sending and wait until every pending result has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // only called with the block drained
  task automatic write_debounce(input logic [15:0] ticks);
    cfg_valid <= 1'b1;
    debounce_ticks <= ticks;
    do @(posedge clk); while (!cfg_ready);
    sb.set_debounce(ticks);
    cur_db = ticks;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // keys held for a number of samples, then all up for a gap
  task automatic press(input logic [15:0] held, input int hold, input int gap);
    for (int i = 0; i < hold; i++) send_rows(rows_under(held, sb.drive_now));
    for (int i = 0; i < gap; i++) send_rows(4'h0);
  endtask

  // held through debounce and the full column scan
  task automatic press_key(input logic [3:0] code, input int extra);
    press(key_mask(code), debounce_span() + 5 + extra, 2);
  endtask

  task automatic random_keys(input int count);
    int stop_at;
    int pick;
    stop_at = items_offered + count;
    while (items_offered < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // clean single key
        press_key(4'($urandom_range(15)), $urandom_range(3));
      end else if (pick < 80) begin
        // several keys at once
        press(16'($urandom_range(65535)), debounce_span() + 5 + $urandom_range(3),
              $urandom_range(1, 3));
      end else if (pick < 88) begin
        // bounce: let go before the debounce check
        press(key_mask(4'($urandom_range(15))), $urandom_range(1, debounce_span()),
              $urandom_range(1, 3));
      end else begin
        // row noise that ignores the column drive
        repeat ($urandom_range(1, 8)) send_rows(4'($urandom_range(15)));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset debounce length: idle rows only, a full press would take thousands of beats
    repeat (20) send_rows(4'h0);
    settle();

    // directed keys with the shortest debounce
    write_debounce(16'd1);
    press_key(kpd_pkg::KEY_CONFIRM[3:0], 0);  // confirm with nothing entered
    press_key(4'd9, 0);
    press_key(4'd9, 2);
    press_key(4'd9, 0);              // third digit finishes at 999
    for (int k = 0; k < 16; k++) press_key(4'(k), k % 3);
    press(key_mask(4'd5), 1, 2);     // bounce
    press(key_mask(4'd1) | key_mask(4'd2), 6, 2);  // two rows in one column
    press(key_mask(4'd7) | key_mask(4'd1), 6, 2);  // later column wins
    press(16'hffff, 6, 2);           // every key down
    press_key(4'd3, 0);              // leave an entry half done
    settle();

    // longest debounce, idle rows only
    write_debounce(16'hffff);
    repeat (20) send_rows(4'h0);
    settle();

    // zero setting, then random traffic at several settings
    write_debounce(16'd0);
    random_keys(200);
    settle();

    write_debounce(16'd1);
    no_idle = 1'b1;
    random_keys(250);
    settle();
    no_idle = 1'b0;

    // long receiver hold-off while keys keep coming
    write_debounce(16'd2);
    random_keys(100);
    stall_request = HOLD_OFF_CYCLES;
    random_keys(200);
    settle();

    repeat (3) begin
      write_debounce(16'($urandom_range(3, 6)));
      random_keys(220);
      settle();
    end

    if (sb.mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
src/kpd_pkg.sv
src/kpd_step.sv
src/keypad_scan_decimal_entry_unit.sv
bench/testbench.sv
